// File: rtl/core/stad_pkg.sv
// Shared types and constants of the sigma threshold anomaly detector.
`timescale 1ns / 1ps

package stad_pkg;

    // Input mode codes
    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_FINISH = 2'd1;
    localparam logic [1:0] MODE_FETCH  = 2'd2;

    // Reset value of the sigma multiplier
    localparam logic [2:0] SIGMA_RESET = 3'd2;

    // Operation classified by the front part
    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_FINISH = 2'd1,
        OP_FETCH  = 2'd2
    } op_t;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_SUMMARY = 2'd0,
        KIND_ANOMALY = 2'd1,
        KIND_END     = 2'd2
    } kind_t;

    // Back part sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_SUM,
        ST_DIV_SQ,
        ST_MUL,
        ST_VAR,
        ST_SQRT,
        ST_LIMIT,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_EMIT
    } state_t;

    // Queue head as seen by the back part
    typedef struct packed {
        logic valid;
        op_t  op;
    } cmd_t;

endpackage

// File: rtl/core/stad_front.sv
// Front part: accepts items, classifies the mode and queues them for the back part.
`timescale 1ns / 1ps

module stad_front #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int TAG_WIDTH    = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [1:0]              mode,
    input  logic [SAMPLE_WIDTH-1:0] sample_value,
    input  logic [TAG_WIDTH-1:0]    sample_tag,
    output stad_pkg::cmd_t          cmd,
    output logic [SAMPLE_WIDTH-1:0] cmd_value,
    output logic [TAG_WIDTH-1:0]    cmd_tag,
    input  logic                    cmd_pop
);

    logic [1:0]              op_q    [2];
    logic [SAMPLE_WIDTH-1:0] value_q [2];
    logic [TAG_WIDTH-1:0]    tag_q   [2];
    logic                    wr_ptr_reg;
    logic                    rd_ptr_reg;
    logic [1:0]              fill_reg;
    logic                    accept;
    logic                    keep;
    stad_pkg::op_t           op_dec;

    // Classify the mode; unused codes are taken and dropped
    always_comb
    begin
        keep   = 1'b1;
        op_dec = stad_pkg::OP_LOAD;
        unique case (mode)
            stad_pkg::MODE_LOAD:   op_dec = stad_pkg::OP_LOAD;
            stad_pkg::MODE_FINISH: op_dec = stad_pkg::OP_FINISH;
            stad_pkg::MODE_FETCH:  op_dec = stad_pkg::OP_FETCH;
            default:               keep   = 1'b0;
        endcase
    end

    assign in_stall = (fill_reg == 2'd2);
    assign accept   = in_valid && !in_stall;

    // Advance queue pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (accept && keep)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (cmd_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            fill_reg <= fill_reg + 2'(accept && keep) - 2'(cmd_pop);
        end
    end

    // Hold queued payload
    always_ff @(posedge clk)
    begin
        if (accept && keep)
        begin
            op_q[wr_ptr_reg]    <= op_dec;
            value_q[wr_ptr_reg] <= sample_value;
            tag_q[wr_ptr_reg]   <= sample_tag;
        end
    end

    assign cmd.valid = (fill_reg != 2'd0);
    assign cmd.op    = stad_pkg::op_t'(op_q[rd_ptr_reg]);
    assign cmd_value = value_q[rd_ptr_reg];
    assign cmd_tag   = tag_q[rd_ptr_reg];

`ifndef ASSERT_OFF
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> fill_reg != 2'd0)
        else $error("queue popped while empty");
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg == 2'd2 |=> fill_reg != 2'd3)
        else $error("queue overfilled");
`endif

endmodule

// File: rtl/core/stad_back.sv
// Back part: sample store, running sums, divider, square root, scan and result register.
`timescale 1ns / 1ps

module stad_back #(
    parameter int MAX_SAMPLES  = 1024,
    parameter int SAMPLE_WIDTH = 16,
    parameter int TAG_WIDTH    = 32,
    localparam int CW          = $clog2(MAX_SAMPLES + 1)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write,
    input  logic [2:0]              cfg_data,
    input  stad_pkg::cmd_t          cmd,
    input  logic [SAMPLE_WIDTH-1:0] cmd_value,
    input  logic [TAG_WIDTH-1:0]    cmd_tag,
    output logic                    cmd_pop,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [1:0]              kind,
    output logic [SAMPLE_WIDTH-1:0] anomaly_value,
    output logic [TAG_WIDTH-1:0]    anomaly_tag,
    output logic [SAMPLE_WIDTH-1:0] mean_value,
    output logic [SAMPLE_WIDTH-1:0] deviation,
    output logic [SAMPLE_WIDTH:0]   limit,
    output logic [CW-1:0]           sample_count,
    output logic                    overflowed
);

    localparam int SW   = SAMPLE_WIDTH;
    localparam int AW   = $clog2(MAX_SAMPLES);
    localparam int SUMW = SW + CW;
    localparam int QW   = (2 * SW + CW > 64) ? 64 : 2 * SW + CW;
    localparam int RW   = (QW + 1) / 2;
    localparam int SCW  = $clog2(QW + 1);
    localparam logic [CW-1:0] MAX_COUNT  = CW'(MAX_SAMPLES);
    localparam logic [RW-1:0] DEV_MAX    = RW'({SW{1'b1}});
    localparam logic [SW:0]   LIMIT_MAX  = {(SW + 1){1'b1}};

    // Sample store
    logic [SW-1:0]        value_mem [MAX_SAMPLES];
    logic [TAG_WIDTH-1:0] tag_mem   [MAX_SAMPLES];

    stad_pkg::state_t st_reg, st_next;

    logic [2:0]        sigma_reg;
    logic [CW-1:0]     count_reg;
    logic [SUMW-1:0]   sum_reg;
    logic [QW-1:0]     sumsq_reg;
    logic [SW:0]       limit_reg;
    logic [CW-1:0]     pos_reg;
    logic              closed_reg;
    logic              dropped_reg;
    logic [SCW-1:0]    step_reg;
    logic              out_valid_reg;

    logic [CW-1:0]     div_rem_reg;
    logic [QW-1:0]     work_reg;
    logic [SW-1:0]     mean_reg;
    logic [QW-1:0]     msq_reg;
    logic [2*SW-1:0]   meansq_reg;
    logic [2*RW-1:0]   sq_op_reg;
    logic [RW-1:0]     root_reg;
    logic [RW+1:0]     sq_rem_reg;
    logic [SW-1:0]     rd_val_reg;
    logic [TAG_WIDTH-1:0] rd_tag_reg;
    stad_pkg::kind_t   pend_kind_reg;
    logic [SW-1:0]     pend_val_reg;
    logic [TAG_WIDTH-1:0] pend_tag_reg;
    logic [SW-1:0]     pend_mean_reg;
    logic [SW-1:0]     pend_dev_reg;
    logic              pend_clear_reg;
    stad_pkg::kind_t   kind_reg;
    logic [SW-1:0]     anomaly_value_reg;
    logic [TAG_WIDTH-1:0] anomaly_tag_reg;
    logic [SW-1:0]     mean_value_reg;
    logic [SW-1:0]     deviation_reg;
    logic [SW:0]       limit_out_reg;
    logic [CW-1:0]     count_out_reg;
    logic              overflowed_reg;

    logic              out_free;
    logic              emit_now;
    logic              do_load;
    logic              last_step;
    logic [CW:0]       div_t_val;
    logic              div_ge;
    logic [CW:0]       div_diff;
    logic [QW-1:0]     work_step;
    logic [RW+2:0]     sq_t_val;
    logic [RW+2:0]     sq_trial;
    logic              sq_ge;
    logic [RW+2:0]     sq_diff;
    logic [QW-1:0]     var_val;
    logic [SW-1:0]     dev_sat;
    logic [SW+3:0]     lim_full;
    logic [SW:0]       lim_sat;
    logic [2*SW-1:0]   sq_prod;
    logic [2*SW-1:0]   mean_prod;
    logic              scan_more;
    logic              is_anomaly;

    assign out_free  = !out_valid_reg || !out_stall;
    assign emit_now  = (st_reg == stad_pkg::ST_EMIT) && out_free;
    assign cmd_pop   = (st_reg == stad_pkg::ST_IDLE) && cmd.valid;
    assign do_load   = cmd_pop && (cmd.op == stad_pkg::OP_LOAD) && !closed_reg;
    assign last_step = (step_reg == SCW'(1));

    // Restoring division step: one quotient bit a cycle
    assign div_t_val = {div_rem_reg, work_reg[QW-1]};
    assign div_ge    = div_t_val >= {1'b0, count_reg};
    assign div_diff  = div_ge ? div_t_val - {1'b0, count_reg} : div_t_val;
    assign work_step = {work_reg[QW-2:0], div_ge};

    // Square root step: one result bit a cycle
    assign sq_t_val = {sq_rem_reg[RW:0], sq_op_reg[2*RW-1 -: 2]};
    assign sq_trial = {1'b0, root_reg, 2'b01};
    assign sq_ge    = sq_t_val >= sq_trial;
    assign sq_diff  = sq_ge ? sq_t_val - sq_trial : sq_t_val;

    // Variance, clamped at zero
    assign var_val = (msq_reg > QW'(meansq_reg)) ? msq_reg - QW'(meansq_reg) : '0;

    // Limit from mean and saturated deviation
    assign dev_sat  = (root_reg > DEV_MAX) ? SW'(DEV_MAX) : root_reg[SW-1:0];
    assign lim_full = (SW + 4)'(mean_reg) + (SW + 4)'(sigma_reg) * (SW + 4)'(dev_sat);
    assign lim_sat  = (lim_full > (SW + 4)'(LIMIT_MAX)) ? LIMIT_MAX : lim_full[SW:0];

    assign sq_prod    = (2 * SW)'(cmd_value) * (2 * SW)'(cmd_value);
    assign mean_prod  = (2 * SW)'(mean_reg) * (2 * SW)'(mean_reg);
    assign scan_more  = pos_reg < count_reg;
    assign is_anomaly = {1'b0, rd_val_reg} > limit_reg;

    // Sequencer state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= stad_pkg::ST_IDLE;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

    // Next state
    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            stad_pkg::ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    case (cmd.op)
                        stad_pkg::OP_FINISH:
                            st_next = (count_reg == '0) ? stad_pkg::ST_EMIT
                                                        : stad_pkg::ST_DIV_SUM;
                        stad_pkg::OP_FETCH:
                            st_next = closed_reg ? stad_pkg::ST_SCAN_RD
                                                 : stad_pkg::ST_EMIT;
                        default:
                            st_next = stad_pkg::ST_IDLE;
                    endcase
                end
            end
            stad_pkg::ST_DIV_SUM:
                if (last_step) st_next = stad_pkg::ST_DIV_SQ;
            stad_pkg::ST_DIV_SQ:
                if (last_step) st_next = stad_pkg::ST_MUL;
            stad_pkg::ST_MUL:
                st_next = stad_pkg::ST_VAR;
            stad_pkg::ST_VAR:
                st_next = stad_pkg::ST_SQRT;
            stad_pkg::ST_SQRT:
                if (last_step) st_next = stad_pkg::ST_LIMIT;
            stad_pkg::ST_LIMIT:
                st_next = stad_pkg::ST_EMIT;
            stad_pkg::ST_SCAN_RD:
                st_next = scan_more ? stad_pkg::ST_SCAN_CHK : stad_pkg::ST_EMIT;
            stad_pkg::ST_SCAN_CHK:
                st_next = is_anomaly ? stad_pkg::ST_EMIT : stad_pkg::ST_SCAN_RD;
            stad_pkg::ST_EMIT:
                if (out_free) st_next = stad_pkg::ST_IDLE;
            default:
                st_next = stad_pkg::ST_IDLE;
        endcase
    end

    // Control registers: set state, sums, counters and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sigma_reg     <= stad_pkg::SIGMA_RESET;
            count_reg     <= '0;
            sum_reg       <= '0;
            sumsq_reg     <= '0;
            limit_reg     <= '0;
            pos_reg       <= '0;
            closed_reg    <= 1'b0;
            dropped_reg   <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                sigma_reg <= cfg_data;
            end

            if (do_load)
            begin
                if (count_reg >= MAX_COUNT)
                begin
                    dropped_reg <= 1'b1;
                end
                else
                begin
                    count_reg <= count_reg + CW'(1);
                    sum_reg   <= sum_reg + SUMW'(cmd_value);
                    sumsq_reg <= sumsq_reg + QW'(sq_prod);
                end
            end

            if (cmd_pop && cmd.op == stad_pkg::OP_FINISH)
            begin
                pos_reg    <= '0;
                closed_reg <= 1'b1;
                step_reg   <= SCW'(QW);
                if (count_reg == '0)
                begin
                    limit_reg <= '0;
                end
            end

            case (st_reg)
                stad_pkg::ST_DIV_SUM,
                stad_pkg::ST_SQRT:
                    step_reg <= last_step ? SCW'(QW) : step_reg - SCW'(1);
                stad_pkg::ST_DIV_SQ:
                    step_reg <= step_reg - SCW'(1);
                stad_pkg::ST_VAR:
                    step_reg <= SCW'(RW);
                stad_pkg::ST_LIMIT:
                    limit_reg <= lim_sat;
                stad_pkg::ST_SCAN_RD:
                    if (scan_more) pos_reg <= pos_reg + CW'(1);
                default:
                begin
                end
            endcase

            // Release the result register, then load it when a result is ready
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (emit_now)
            begin
                out_valid_reg <= 1'b1;
                if (pend_clear_reg)
                begin
                    count_reg   <= '0;
                    sum_reg     <= '0;
                    sumsq_reg   <= '0;
                    limit_reg   <= '0;
                    pos_reg     <= '0;
                    closed_reg  <= 1'b0;
                    dropped_reg <= 1'b0;
                end
            end
        end
    end

    // Write the store on a load below capacity
    always_ff @(posedge clk)
    begin
        if (do_load && count_reg < MAX_COUNT)
        begin
            value_mem[count_reg[AW-1:0]] <= cmd_value;
            tag_mem[count_reg[AW-1:0]]   <= cmd_tag;
        end
    end

    // Read the store during the scan
    always_ff @(posedge clk)
    begin
        if (st_reg == stad_pkg::ST_SCAN_RD && scan_more)
        begin
            rd_val_reg <= value_mem[pos_reg[AW-1:0]];
            rd_tag_reg <= tag_mem[pos_reg[AW-1:0]];
        end
    end

    // Arithmetic and pending result datapath
    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            div_rem_reg    <= '0;
            work_reg       <= QW'(sum_reg);
            pend_kind_reg  <= (cmd.op == stad_pkg::OP_FINISH) ? stad_pkg::KIND_SUMMARY
                                                              : stad_pkg::KIND_END;
            pend_val_reg   <= '0;
            pend_tag_reg   <= '0;
            pend_mean_reg  <= '0;
            pend_dev_reg   <= '0;
            pend_clear_reg <= 1'b0;
        end

        case (st_reg)
            stad_pkg::ST_DIV_SUM:
            begin
                if (last_step)
                begin
                    mean_reg    <= work_step[SW-1:0];
                    work_reg    <= sumsq_reg;
                    div_rem_reg <= '0;
                end
                else
                begin
                    work_reg    <= work_step;
                    div_rem_reg <= div_diff[CW-1:0];
                end
            end
            stad_pkg::ST_DIV_SQ:
            begin
                work_reg    <= work_step;
                div_rem_reg <= div_diff[CW-1:0];
                if (last_step)
                begin
                    msq_reg <= work_step;
                end
            end
            stad_pkg::ST_MUL:
                meansq_reg <= mean_prod;
            stad_pkg::ST_VAR:
            begin
                sq_op_reg  <= (2 * RW)'(var_val);
                root_reg   <= '0;
                sq_rem_reg <= '0;
            end
            stad_pkg::ST_SQRT:
            begin
                sq_op_reg  <= {sq_op_reg[2*RW-3:0], 2'b00};
                root_reg   <= {root_reg[RW-2:0], sq_ge};
                sq_rem_reg <= sq_diff[RW+1:0];
            end
            stad_pkg::ST_LIMIT:
            begin
                pend_mean_reg <= mean_reg;
                pend_dev_reg  <= dev_sat;
            end
            stad_pkg::ST_SCAN_RD:
                if (!scan_more) pend_clear_reg <= 1'b1;
            stad_pkg::ST_SCAN_CHK:
            begin
                if (is_anomaly)
                begin
                    pend_kind_reg <= stad_pkg::KIND_ANOMALY;
                    pend_val_reg  <= rd_val_reg;
                    pend_tag_reg  <= rd_tag_reg;
                end
            end
            default:
                root_reg <= root_reg;
        endcase

        // Load the result register from the pending result
        if (emit_now)
        begin
            kind_reg          <= pend_kind_reg;
            anomaly_value_reg <= pend_val_reg;
            anomaly_tag_reg   <= pend_tag_reg;
            mean_value_reg    <= pend_mean_reg;
            deviation_reg     <= pend_dev_reg;
            limit_out_reg     <= limit_reg;
            count_out_reg     <= count_reg;
            overflowed_reg    <= dropped_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign kind          = kind_reg;
    assign anomaly_value = anomaly_value_reg;
    assign anomaly_tag   = anomaly_tag_reg;
    assign mean_value    = mean_value_reg;
    assign deviation     = deviation_reg;
    assign limit         = limit_out_reg;
    assign sample_count  = count_out_reg;
    assign overflowed    = overflowed_reg;

`ifndef ASSERT_OFF
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> st_reg == stad_pkg::ST_IDLE)
        else $error("item taken while busy");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_COUNT)
        else $error("sample count above capacity");
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        emit_now |-> !(out_valid_reg && out_stall))
        else $error("result register overwritten");
`endif

endmodule

// File: rtl/core/sigma_threshold_anomaly_detector_top.sv
// Top level of the sigma threshold anomaly detector.
// Loads: one item a cycle while the back idles; absorbed on leaving the two-entry queue.
// Finish: divides the sum and the sum of squares by the count, Q = min(2*SAMPLE_WIDTH +
// count bits, 64) quotient bits each, then an R = ceil(Q/2) bit square root and the limit.
// Fetch: reads then checks stored entries through the single read port, up to an anomaly.
// Reset is asynchronous active low, clears set state at once; the store is not cleared.
`timescale 1ns / 1ps

module sigma_threshold_anomaly_detector_top #(
    parameter int MAX_SAMPLES  = 1024,
    parameter int SAMPLE_WIDTH = 16,
    parameter int TAG_WIDTH    = 32,
    localparam int CW          = $clog2(MAX_SAMPLES + 1)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write,
    input  logic [2:0]              cfg_data,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [1:0]              mode,
    input  logic [SAMPLE_WIDTH-1:0] sample_value,
    input  logic [TAG_WIDTH-1:0]    sample_tag,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [1:0]              kind,
    output logic [SAMPLE_WIDTH-1:0] anomaly_value,
    output logic [TAG_WIDTH-1:0]    anomaly_tag,
    output logic [SAMPLE_WIDTH-1:0] mean_value,
    output logic [SAMPLE_WIDTH-1:0] deviation,
    output logic [SAMPLE_WIDTH:0]   limit,
    output logic [CW-1:0]           sample_count,
    output logic                    overflowed
);

    stad_pkg::cmd_t          cmd;
    logic [SAMPLE_WIDTH-1:0] cmd_value;
    logic [TAG_WIDTH-1:0]    cmd_tag;
    logic                    cmd_pop;

    // Accept and queue items
    stad_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .TAG_WIDTH    (TAG_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .sample_value (sample_value),
        .sample_tag   (sample_tag),
        .cmd          (cmd),
        .cmd_value    (cmd_value),
        .cmd_tag      (cmd_tag),
        .cmd_pop      (cmd_pop)
    );

    // Carry out queued items
    stad_back #(
        .MAX_SAMPLES  (MAX_SAMPLES),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .TAG_WIDTH    (TAG_WIDTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .cmd_value     (cmd_value),
        .cmd_tag       (cmd_tag),
        .cmd_pop       (cmd_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .anomaly_value (anomaly_value),
        .anomaly_tag   (anomaly_tag),
        .mean_value    (mean_value),
        .deviation     (deviation),
        .limit         (limit),
        .sample_count  (sample_count),
        .overflowed    (overflowed)
    );

endmodule
